// ===== rtl/core/tile_min_max_map_unit_assert.svh =====
// Assertion macros for the tile min/max map unit.
// Expects clk and rst in the scope of each use.
`ifndef TILE_MIN_MAX_MAP_UNIT_ASSERT_SVH
`define TILE_MIN_MAX_MAP_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TMM_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define TMM_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/tmm_pkg.sv =====
// Shared constants and types for the tile min/max map unit.
// No dependencies; used by tmm_div and tile_min_max_map_unit.
`timescale 1ns / 1ps

package tmm_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_TILES_X  = 2048;
  localparam int SLOT_BITS    = $clog2(MAX_TILES_X);

  localparam int WIDTH_BITS   = 13;
  localparam int HEIGHT_BITS  = 16;
  localparam int QUAD_BITS    = 9;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int COL_BITS     = 11;
  localparam int ROW_BITS     = 15;

  // divider covers the widest counter (row count)
  localparam int DIV_BITS     = 16;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam int BANK_WORD    = 2 * SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MASK = sample_t'((17'd1 << SAMPLE_BITS) - 17'd1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUAD_SIZE    = 2'd2;

  localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH  = 13'd1025;
  localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT = 16'd1025;
  localparam logic [QUAD_BITS-1:0]   RST_QUAD_SIZE    = 9'd8;

endpackage

// ===== rtl/core/tmm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`timescale 1ns / 1ps

module tmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tmm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on tmm_pkg for widths.
`timescale 1ns / 1ps

module tmm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tmm_pkg::DIV_BITS-1:0]  dividend,
  input  logic [tmm_pkg::QUAD_BITS-1:0] divisor,
  output logic                          done,
  output logic [tmm_pkg::DIV_BITS-1:0]  quotient,
  output logic [tmm_pkg::QUAD_BITS-1:0] remainder
);
  import tmm_pkg::*;

  logic                    run;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0]     dvd;
  logic [QUAD_BITS-1:0]    dvs;
  logic [QUAD_BITS:0]      rem_sh;
  logic                    ge;
  logic [QUAD_BITS-1:0]    rem_new;

  assign rem_sh  = {remainder, dvd[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  // rem_sh < 2*dvs, so the difference fits the divisor width
  assign rem_new = ge ? QUAD_BITS'(rem_sh - {1'b0, dvs}) : rem_sh[QUAD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run       <= 1'b1;
        cnt       <= '0;
        dvd       <= dividend;
        dvs       <= divisor;
        remainder <= '0;
        quotient  <= '0;
      end else if (run) begin
        remainder <= rem_new;
        quotient  <= {quotient[DIV_BITS-2:0], ge};
        dvd       <= {dvd[DIV_BITS-2:0], 1'b0};
        cnt       <= cnt + 1'b1;
        if (cnt == DIV_CNT_BITS'(DIV_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tile_min_max_map_unit.sv =====
// Tile min/max map unit: running per-quad min/max over a raster height image.
// Depends on tmm_pkg, tmm_ram, tmm_div and tile_min_max_map_unit_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall, height_sample) takes one height word
//   per cycle while in_stall is low, in raster order. Output channel
//   (out_valid / out_stall) gives one word per completed quad: tile_min,
//   tile_max, tile_col, tile_row and last_tile on the final quad of the image.
//   Config port (cfg_wen, cfg_index, cfg_data) sets image_width (0),
//   image_height (1) and quad_size (2); write only while the block is idle.
// Timing:
//   Rate is one sample per cycle while in_stall is low. The per-column
//   min/max banks sit in two RAMs read at a segment end and written back
//   as stage 1 retires; a quad's result goes through stage 1 and the output
//   register. A quad_size write re-derives the column and row phase
//   counters with a one-bit-per-cycle divider; input stalls meanwhile.
// Reset:
//   Counters, bank select and running min/max clear; the bank RAMs are not
//   cleared and are always written before they are read within an image.
// Backpressure:
//   A stalled output word holds; the block keeps taking samples until a
//   second result is ready behind it, then stalls the input.
`timescale 1ns / 1ps
`include "tile_min_max_map_unit_assert.svh"

module tile_min_max_map_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [tmm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tmm_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tmm_pkg::SAMPLE_BITS-1:0]  height_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmm_pkg::SAMPLE_BITS-1:0]  tile_min,
  output logic [tmm_pkg::SAMPLE_BITS-1:0]  tile_max,
  output logic [tmm_pkg::COL_BITS-1:0]     tile_col,
  output logic [tmm_pkg::ROW_BITS-1:0]     tile_row,
  output logic                             last_tile
);
  import tmm_pkg::*;

  // configuration
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [QUAD_BITS-1:0]   quad_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      quad_size    <= RST_QUAD_SIZE;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
        CFG_QUAD_SIZE:    quad_size    <= cfg_data[QUAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [QUAD_BITS-1:0]   q_eff;
  logic [WIDTH_BITS-1:0]  wlast;
  logic [HEIGHT_BITS-1:0] hlast;

  assign q_eff = (quad_size == '0) ? QUAD_BITS'(1) : quad_size;
  assign wlast = (image_width == '0) ? '0 : image_width - 1'b1;
  assign hlast = (image_height == '0) ? '0 : image_height - 1'b1;

  // position counters: c = cq*q + cr, r = rq*q + rr
  logic [WIDTH_BITS-1:0]  c, cq;
  logic [QUAD_BITS-1:0]   cr, rr;
  logic [HEIGHT_BITS-1:0] r, rq;
  logic                   bank;
  sample_t                run_min, run_max;

  // phase recompute sequencer after a quad_size write
  typedef enum logic [2:0] {
    RP_IDLE, RP_COL_START, RP_COL_WAIT, RP_ROW_START, RP_ROW_WAIT
  } rp_state_t;
  rp_state_t rp_state;

  logic                 div_start, div_done;
  logic [DIV_BITS-1:0]  div_dividend, div_quo;
  logic [QUAD_BITS-1:0] div_rem;
  logic                 busy;
  logic                 quad_wr;

  assign quad_wr      = cfg_wen && (cfg_index == CFG_QUAD_SIZE);
  assign busy         = (rp_state != RP_IDLE);
  assign div_start    = (rp_state == RP_COL_START) || (rp_state == RP_ROW_START);
  assign div_dividend = (rp_state == RP_COL_START) ? DIV_BITS'(c) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      rp_state <= RP_IDLE;
    end else if (quad_wr) begin
      rp_state <= RP_COL_START;
    end else begin
      case (rp_state)
        RP_COL_START: rp_state <= RP_COL_WAIT;
        RP_COL_WAIT:  if (div_done) rp_state <= RP_ROW_START;
        RP_ROW_START: rp_state <= RP_ROW_WAIT;
        RP_ROW_WAIT:  if (div_done) rp_state <= RP_IDLE;
        default:      rp_state <= RP_IDLE;
      endcase
    end
  end

  tmm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (q_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // stage 1 (bank read returned) and output register
  logic                 s1_valid, s1_bank, s1_first, s1_emit, s1_seed, s1_last;
  sample_t              s1_min, s1_max;
  logic [SLOT_BITS-1:0] s1_slot;
  logic [COL_BITS-1:0]  s1_col;
  logic [ROW_BITS-1:0]  s1_row;
  logic                 blk, s1_retire, in_acc;

  assign blk       = s1_valid && s1_emit && out_valid && out_stall;
  assign in_stall  = busy || blk;
  assign in_acc    = in_valid && !in_stall;
  assign s1_retire = s1_valid && !blk;

  // stage 0: sample against current position
  sample_t              h, cur_min, cur_max;
  logic                 c_end, r_end, ev, row_first;
  logic [WIDTH_BITS-1:0]  qx;
  logic [HEIGHT_BITS-1:0] qy;

  assign h         = height_sample & SAMPLE_MASK;
  assign cur_min   = (c == '0) ? h : ((h < run_min) ? h : run_min);
  assign cur_max   = (c == '0) ? h : ((h > run_max) ? h : run_max);
  assign c_end     = (c >= wlast);
  assign r_end     = (r >= hlast);
  assign ev        = (c != '0) && ((cr == '0) || c_end);
  assign row_first = (r == '0);
  // (c-1)/q and (r-1)/q from quotient and remainder
  assign qx        = (cr == '0) ? cq - 1'b1 : cq;
  assign qy        = (rr == '0) ? rq - 1'b1 : rq;

  logic [QUAD_BITS:0] cr_inc, rr_inc;
  assign cr_inc = {1'b0, cr} + 1'b1;
  assign rr_inc = {1'b0, rr} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c       <= '0;
      cq      <= '0;
      cr      <= '0;
      r       <= '0;
      rq      <= '0;
      rr      <= '0;
      bank    <= 1'b0;
      run_min <= SAMPLE_MASK;
      run_max <= '0;
    end else if (div_done && (rp_state == RP_COL_WAIT)) begin
      cq <= div_quo[WIDTH_BITS-1:0];
      cr <= div_rem;
    end else if (div_done && (rp_state == RP_ROW_WAIT)) begin
      rq <= div_quo;
      rr <= div_rem;
    end else if (in_acc) begin
      run_min <= (ev || (c == '0)) ? h : cur_min;
      run_max <= (ev || (c == '0)) ? h : cur_max;
      if (c_end) begin
        c  <= '0;
        cq <= '0;
        cr <= '0;
        if (r_end) begin
          r    <= '0;
          rq   <= '0;
          rr   <= '0;
          bank <= 1'b0;
        end else begin
          if (!row_first && (rr == '0)) bank <= ~bank;
          r <= r + 1'b1;
          if (rr_inc == {1'b0, q_eff}) begin
            rr <= '0;
            rq <= rq + 1'b1;
          end else begin
            rr <= rr_inc[QUAD_BITS-1:0];
          end
        end
      end else begin
        c <= c + 1'b1;
        if (cr_inc == {1'b0, q_eff}) begin
          cr <= '0;
          cq <= cq + 1'b1;
        end else begin
          cr <= cr_inc[QUAD_BITS-1:0];
        end
      end
    end
  end

  logic [SLOT_BITS-1:0] slot;
  assign slot = qx[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= ev;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && ev) begin
      s1_bank  <= bank;
      s1_first <= row_first;
      s1_emit  <= !row_first && ((rr == '0) || r_end);
      s1_seed  <= !row_first && (rr == '0) && !r_end;
      s1_last  <= c_end && r_end;
      s1_min   <= cur_min;
      s1_max   <= cur_max;
      s1_slot  <= slot;
      s1_col   <= qx[COL_BITS-1:0];
      s1_row   <= qy[ROW_BITS-1:0];
    end
  end

  // bank RAMs, word = {min, max}
  logic [BANK_WORD-1:0] rd_a, rd_b, cur_word, merged, seed_word;
  logic                 wr_a, wr_b;
  sample_t              m_min, m_max;

  assign cur_word  = s1_bank ? rd_b : rd_a;
  assign m_min     = (s1_first || (s1_min < cur_word[BANK_WORD-1:SAMPLE_BITS]))
                     ? s1_min : cur_word[BANK_WORD-1:SAMPLE_BITS];
  assign m_max     = (s1_first || (s1_max > cur_word[SAMPLE_BITS-1:0]))
                     ? s1_max : cur_word[SAMPLE_BITS-1:0];
  assign merged    = {m_min, m_max};
  assign seed_word = {s1_min, s1_max};
  assign wr_a      = s1_retire && (!s1_bank || s1_seed);
  assign wr_b      = s1_retire && (s1_bank || s1_seed);

  tmm_ram #(.WIDTH(BANK_WORD), .DEPTH(MAX_TILES_X)) u_bank_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (s1_slot),
    .wr_data (s1_bank ? seed_word : merged),
    .rd_en   (in_acc && ev),
    .rd_addr (slot),
    .rd_data (rd_a)
  );

  tmm_ram #(.WIDTH(BANK_WORD), .DEPTH(MAX_TILES_X)) u_bank_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (s1_slot),
    .wr_data (s1_bank ? merged : seed_word),
    .rd_en   (in_acc && ev),
    .rd_addr (slot),
    .rd_data (rd_b)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_retire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_retire && s1_emit) begin
      tile_min  <= m_min;
      tile_max  <= m_max;
      tile_col  <= s1_col;
      tile_row  <= s1_row;
      last_tile <= s1_last;
    end
  end

  // phase counters stay below the quad size whenever samples flow
  `TMM_ASSERT_SAME(a_phase_range, !busy, (cr < q_eff) && (rr < q_eff), "phase out of range")
  // back-to-back segment ends never hit the slot still being written back
  `TMM_ASSERT_SAME(a_slot_clash, s1_valid && in_acc && ev, slot != s1_slot, "bank slot clash")
  // a retiring result always lands in the output register
  `TMM_ASSERT_NEXT(a_result_lands, s1_retire && s1_emit, out_valid, "result word lost")

endmodule
